[rtl/cars_pkg.sv]
// package for the chromatic aberration row shift block
// types, widths and register codes shared by the window memory and the top level
// no dependencies
`timescale 1ns / 1ps

package cars_pkg;

  localparam int PIXEL_W   = 32;
  localparam int BYTE_W    = 8;
  localparam int AMT_W     = 5;                 // shift amount width
  localparam int COL_W     = 6;                 // saturating column counter
  localparam int ADDR_W    = 6;                 // window memory address
  localparam int WIN_DEPTH = 1 << ADDR_W;       // holds more than 2*max shift + 1 pixels
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

  typedef logic [ADDR_W-1:0] win_addr_t;

  // register index, taken from paddr above the byte lanes
  typedef enum logic [0:0] {
    REG_SHIFT_AMOUNT = 1'b0
  } reg_idx_t;

  // one window lookup: own pixel plus its left and right neighbours
  typedef struct packed {
    win_addr_t own_addr;
    win_addr_t left_addr;
    win_addr_t right_addr;
  } rd_req_t;

endpackage

[rtl/cars_window.sv]
// pixel window memory: circular store of recent pixels of the row
// one write port, one registered read per copy; uses cars_pkg
`timescale 1ns / 1ps

module cars_window
  import cars_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  win_addr_t          wr_addr,
  input  logic [PIXEL_W-1:0] wr_data,
  input  logic               rd_en,
  input  rd_req_t            rd_req,
  output logic [PIXEL_W-1:0] own_q,
  output logic [BYTE_W-1:0]  left_q,
  output logic [BYTE_W-1:0]  right_q
);

  // full pixel for the own lookup, only the borrowed byte for each neighbour
  logic [PIXEL_W-1:0] own_mem   [WIN_DEPTH];
  logic [BYTE_W-1:0]  left_mem  [WIN_DEPTH];
  logic [BYTE_W-1:0]  right_mem [WIN_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      own_mem[wr_addr]   <= wr_data;
      left_mem[wr_addr]  <= wr_data[4*BYTE_W-1:3*BYTE_W];
      right_mem[wr_addr] <= wr_data[2*BYTE_W-1:BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      own_q   <= own_mem[rd_req.own_addr];
      left_q  <= left_mem[rd_req.left_addr];
      right_q <= right_mem[rd_req.right_addr];
    end
  end

endmodule

[rtl/chromatic_aberration_row_shift_top.sv]
// top level of the chromatic aberration row shift block
// control, configuration register and output stage; uses cars_pkg and cars_window
`timescale 1ns / 1ps

// Chromatic aberration row shift. Pixels stream in row order, one beat per pixel,
// with row_end_in on the last pixel of each row. Every output pixel takes its top
// byte from the pixel shift_amount columns to its left and byte 1 from the pixel
// shift_amount columns to its right, when those lie inside the row and the left one
// is not column 0; otherwise the pixel keeps its own byte. Column x leaves once
// column x+a has arrived, so inside a row the block takes and gives one beat per
// clock unless the output stalls. A row end with a shift of a, arriving at column x,
// flushes min(x,a)+1 result beats, one per clock unless the output stalls, because
// each result needs its own lookup in the window memory; the input is stalled until
// the last lookup issues. Results pass the job and read stages into the output
// register. Write shift_amount only between rows while the block is idle; a new
// value applies to the next accepted beat. No memory clearing is needed after reset.

module chromatic_aberration_row_shift_top
  import cars_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // pixel input channel
  input  logic               src_valid,
  output logic               src_stall,
  input  logic [PIXEL_W-1:0] pixel_in,
  input  logic               row_end_in,
  // pixel output channel
  output logic               dst_valid,
  input  logic               dst_stall,
  output logic [PIXEL_W-1:0] pixel_out,
  output logic               row_end_out
);

  // configuration
  logic [AMT_W-1:0] shift_amount;
  reg_idx_t         reg_idx;

  // input side: write pointer and saturating column count
  win_addr_t        wptr;
  logic [COL_W-1:0] column_count;

  // job stage: one accepted pixel, issuing zero or more window lookups
  logic             job_valid;
  win_addr_t        job_ptr;       // address of the newest pixel
  logic [COL_W-1:0] job_col;       // its column (saturated)
  logic             job_row_end;
  logic [AMT_W-1:0] job_dist;      // distance behind the newest pixel of the next lookup
  logic [AMT_W-1:0] job_dist_next;

  // read stage: registered memory data plus flags
  logic             rd_valid;
  logic             rd_left_ok;
  logic             rd_right_ok;
  logic             rd_last;

  // handshake and flow control
  logic             in_acc;
  logic             out_free;
  logic             rd_free;
  logic             job_need;
  logic             job_last;
  logic             issue;
  logic             job_done;
  logic             job_free;

  // lookup of the current job
  rd_req_t          req;
  win_addr_t        own_addr;
  logic             left_ok;
  logic             right_ok;
  logic [COL_W:0]   left_reach;
  logic [AMT_W-1:0] flush_dist;

  // window memory outputs
  logic [PIXEL_W-1:0] own_q;
  logic [BYTE_W-1:0]  left_q;
  logic [BYTE_W-1:0]  right_q;

  //--------------------------------------------------------------------------
  // configuration register, always ready, no wait states
  //--------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_amount <= '0;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_SHIFT_AMOUNT) begin
      shift_amount <= pwdata[AMT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SHIFT_AMOUNT: prdata = {{(PDATA_W-AMT_W){1'b0}}, shift_amount};
      default:          prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // flow control: each stage moves when the one after it has room
  //--------------------------------------------------------------------------
  assign out_free = !dst_valid || !dst_stall;
  assign rd_free  = !rd_valid || out_free;

  // a plain pixel emits column x-a once x >= a; a row end always flushes
  assign job_need = job_row_end || (job_col >= {1'b0, shift_amount});
  assign job_last = !job_row_end || (job_dist == '0);
  assign issue    = job_valid && job_need && rd_free;
  assign job_done = job_valid && (!job_need || (issue && job_last));
  assign job_free = !job_valid || job_done;

  assign src_stall = !job_free;
  assign in_acc    = src_valid && !src_stall;

  //--------------------------------------------------------------------------
  // input side: write the window, track the column
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr         <= '0;
      column_count <= '0;
    end else if (in_acc) begin
      wptr <= wptr + win_addr_t'(1);
      if (row_end_in) begin
        column_count <= '0;
      end else if (column_count != COL_MAX) begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // flush starts at min(x, a) pixels behind the row end
  assign flush_dist = (column_count < {1'b0, shift_amount}) ? column_count[AMT_W-1:0]
                                                             : shift_amount;

  //--------------------------------------------------------------------------
  // job stage
  //--------------------------------------------------------------------------
  always_comb begin
    job_dist_next = job_dist;
    if (in_acc) begin
      job_dist_next = row_end_in ? flush_dist : shift_amount;
    end else if (issue) begin
      job_dist_next = job_dist - AMT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_acc) begin
      job_valid <= 1'b1;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    job_dist <= job_dist_next;
    if (in_acc) begin
      job_ptr     <= wptr;
      job_col     <= column_count;
      job_row_end <= row_end_in;
    end
  end

  // lookup addresses wrap around the circular window
  assign own_addr   = job_ptr - win_addr_t'(job_dist);
  assign left_reach = {2'b00, job_dist} + {2'b00, shift_amount};
  assign left_ok    = {1'b0, job_col} > left_reach;
  assign right_ok   = job_dist >= shift_amount;

  always_comb begin
    req.own_addr   = own_addr;
    req.left_addr  = own_addr - win_addr_t'(shift_amount);
    req.right_addr = own_addr + win_addr_t'(shift_amount);
  end

  //--------------------------------------------------------------------------
  // window memory
  //--------------------------------------------------------------------------
  cars_window u_window (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wptr),
    .wr_data (pixel_in),
    .rd_en   (issue),
    .rd_req  (req),
    .own_q   (own_q),
    .left_q  (left_q),
    .right_q (right_q)
  );

  //--------------------------------------------------------------------------
  // read stage flags, loaded with the memory read
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (issue) begin
      rd_valid <= 1'b1;
    end else if (out_free) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_left_ok  <= left_ok;
      rd_right_ok <= right_ok;
      rd_last     <= job_row_end && (job_dist == '0);
    end
  end

  //--------------------------------------------------------------------------
  // output register: byte mix of own pixel and neighbours
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_free) begin
      dst_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && rd_valid) begin
      pixel_out <= {rd_left_ok  ? left_q  : own_q[4*BYTE_W-1:3*BYTE_W],
                    own_q[3*BYTE_W-1:2*BYTE_W],
                    rd_right_ok ? right_q : own_q[2*BYTE_W-1:BYTE_W],
                    own_q[BYTE_W-1:0]};
      row_end_out <= rd_last;
    end
  end

  //--------------------------------------------------------------------------
  // assertions
  //--------------------------------------------------------------------------

  // no new pixel may enter while a row end is still flushing
  assert property (@(posedge clk) disable iff (rst)
    job_valid && job_row_end && (job_dist != '0) |-> !in_acc)
    else $error("pixel accepted during row end flush");

  // a read stage beat held by a stalled output keeps its flags
  assert property (@(posedge clk) disable iff (rst)
    rd_valid && dst_valid && dst_stall |=> rd_valid && $stable(rd_last)
      && $stable(rd_left_ok) && $stable(rd_right_ok))
    else $error("read stage beat lost under output stall");

  // the column restarts after every row end
  assert property (@(posedge clk) disable iff (rst)
    in_acc && row_end_in |=> column_count == '0)
    else $error("column count not cleared at row end");

endmodule
